// ----- rtl/core/sorted_slot_table_top_defines.svh -----
// Assertion macros used by the checker file.
`ifndef SORTED_SLOT_TABLE_TOP_DEFINES_SVH
`define SORTED_SLOT_TABLE_TOP_DEFINES_SVH

// a holds on this edge -> b holds on the same edge
`define SST_ASSERT_SAME(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("sst check failed");

// a holds on this edge -> b holds on the next edge
`define SST_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("sst check failed");

`endif

// ----- rtl/core/sst_pkg.sv -----
package sst_pkg;

  localparam int ID_W   = 16;
  localparam int SIZE_W = 8;
  localparam int HELD_W = 5;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BUSY     = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] size;
    logic              busy;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_DEL_RD,
    S_DEL_CMP,
    S_SH_RD,
    S_SH_WR,
    S_RESULT
  } state_t;

endpackage

// ----- rtl/core/sst_ram.sv -----
module sst_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/sorted_slot_table_top.sv -----
// Sorted slot table: keeps up to TABLE_DEPTH entries (id, size, busy) in
// ascending size order in a single-port-per-direction RAM. One transaction in
// gives one transaction out. Insert walks down from the tail, moving each entry
// whose size is not smaller up one slot (a read state, then a compare-and-write
// state per moved entry), then drops the new entry in, then goes to the result
// state; a full table goes straight to the result state. Delete scans up from
// slot 0 for the first matching id (giving up as not found past the last
// entry), and if that entry is free, closes the gap by moving each entry after
// it down one slot, then goes to the result state. Every step is one RAM read
// followed by one compare and one write, so the RAM read latency sets the pace.
// A new command can be taken while the previous result is still waiting on
// out_ready.
module sorted_slot_table_top #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       cmd,
  input  logic [sst_pkg::ID_W-1:0]   table_id,
  input  logic [sst_pkg::SIZE_W-1:0] slot_size,
  input  logic                       busy_flag,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 status,
  output logic [sst_pkg::HELD_W-1:0] entries_held
);
  import sst_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

  state_t state, state_next;

  // command latched at accept
  logic [ID_W-1:0]   op_id;
  logic [SIZE_W-1:0] op_size;
  logic              op_busy;
  entry_t            new_entry;

  // walk index and entry count, both able to hold TABLE_DEPTH
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx_dec, idx_inc;
  status_t       fin_status, fin_status_next;

  // output register
  status_t     res_status;
  logic [CW-1:0] res_count;

  // RAM port
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  entry_t        rd_data, wr_data;

  logic in_fire, out_load;

  assign in_fire   = in_valid && in_ready;
  assign in_ready  = (state == S_IDLE);
  assign out_load  = (state == S_RESULT) && (!out_valid || out_ready);
  assign idx_dec   = idx - 1'b1;
  assign idx_inc   = idx + 1'b1;
  assign new_entry = '{id: op_id, size: op_size, busy: op_busy};

  assign status       = res_status;
  assign entries_held = HELD_W'(res_count);

  sst_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (cmd == CMD_INSERT) begin
            state_next = (count == FULL_COUNT) ? S_RESULT : S_INS_RD;
          end else begin
            state_next = S_DEL_RD;
          end
        end
      end
      S_INS_RD:  state_next = (idx == '0) ? S_RESULT : S_INS_CMP;
      S_INS_CMP: state_next = (rd_data.size >= op_size) ? S_INS_RD : S_RESULT;
      S_DEL_RD:  state_next = (idx == count) ? S_RESULT : S_DEL_CMP;
      S_DEL_CMP: begin
        if (rd_data.id == op_id) begin
          state_next = rd_data.busy ? S_RESULT : S_SH_RD;
        end else begin
          state_next = S_DEL_RD;
        end
      end
      S_SH_RD:   state_next = (idx_inc == count) ? S_RESULT : S_SH_WR;
      S_SH_WR:   state_next = S_SH_RD;
      S_RESULT:  state_next = out_load ? S_IDLE : S_RESULT;
      default:   state_next = S_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    idx_next        = idx;
    count_next      = count;
    fin_status_next = fin_status;
    rd_en           = 1'b0;
    rd_addr         = idx[AW-1:0];
    wr_en           = 1'b0;
    wr_addr         = idx[AW-1:0];
    wr_data         = new_entry;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (cmd == CMD_INSERT) begin
            idx_next        = count;
            fin_status_next = STAT_FULL;
          end else begin
            idx_next        = '0;
          end
        end
      end
      S_INS_RD: begin
        if (idx == '0) begin
          wr_en           = 1'b1;
          count_next      = count + 1'b1;
          fin_status_next = STAT_OK;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_dec[AW-1:0];
        end
      end
      S_INS_CMP: begin
        wr_en = 1'b1;
        if (rd_data.size >= op_size) begin
          // move neighbor up one slot and keep walking down
          wr_data  = rd_data;
          idx_next = idx_dec;
        end else begin
          count_next      = count + 1'b1;
          fin_status_next = STAT_OK;
        end
      end
      S_DEL_RD: begin
        if (idx == count) begin
          fin_status_next = STAT_NOTFOUND;
        end else begin
          rd_en = 1'b1;
        end
      end
      S_DEL_CMP: begin
        if (rd_data.id == op_id) begin
          if (rd_data.busy) begin
            fin_status_next = STAT_BUSY;
          end
        end else begin
          idx_next = idx_inc;
        end
      end
      S_SH_RD: begin
        if (idx_inc == count) begin
          count_next      = count - 1'b1;
          fin_status_next = STAT_OK;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_inc[AW-1:0];
        end
      end
      S_SH_WR: begin
        wr_en    = 1'b1;
        wr_data  = rd_data;
        idx_next = idx_inc;
      end
      S_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    fin_status <= fin_status_next;
    if (in_fire) begin
      op_id   <= table_id;
      op_size <= slot_size;
      op_busy <= busy_flag;
    end
    if (out_load) begin
      res_status <= fin_status;
      res_count  <= count;
    end
  end

endmodule

// ----- rtl/core/sst_checker.sv -----
module sst_checker #(
  parameter int TABLE_DEPTH = 16
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [1:0]                 status,
  input logic [sst_pkg::HELD_W-1:0] entries_held
);
  import sst_pkg::*;
  `include "sorted_slot_table_top_defines.svh"

  localparam logic [HELD_W-1:0] FULL_HELD = HELD_W'(TABLE_DEPTH);

  // a result waiting on the sink holds its value
  `SST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(status) && $stable(entries_held))

  // a full reject reports a completely filled table
  `SST_ASSERT_SAME(a_full_count, out_valid && (status == STAT_FULL),
                   entries_held == FULL_HELD)

  // accepting a command drops in_ready
  `SST_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

endmodule

bind sorted_slot_table_top sst_checker #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_sst_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .entries_held (entries_held)
);

// ----- verif/tb_sorted_slot_table_top.sv -----
`timescale 1ns / 1ps

import sst_pkg::*;

typedef struct packed {
  status_t           status;
  logic [HELD_W-1:0] held;
} table_reply_t;

// Shadow copy of the sorted table plus the replies it still owes
class slot_table_tracker;
  localparam int DEPTH = 16;

  logic [ID_W-1:0]   ids   [DEPTH];
  logic [SIZE_W-1:0] sizes [DEPTH];
  logic              busy  [DEPTH];
  int unsigned       held;
  table_reply_t      pending_replies[$];
  int unsigned       mismatches;

  function new();
    held       = 0;
    mismatches = 0;
  endfunction

  function status_t insert_entry(logic [ID_W-1:0] id, logic [SIZE_W-1:0] sz, logic b);
    int unsigned pos;
    pos = 0;
    if (held >= DEPTH) return STAT_FULL;
    // new entry goes ahead of entries with an equal size
    while (pos < held && sz > sizes[pos]) pos++;
    for (int unsigned k = held; k > pos; k--) begin
      ids[k]   = ids[k-1];
      sizes[k] = sizes[k-1];
      busy[k]  = busy[k-1];
    end
    ids[pos]   = id;
    sizes[pos] = sz;
    busy[pos]  = b;
    held++;
    return STAT_OK;
  endfunction

  function status_t remove_entry(logic [ID_W-1:0] id);
    int unsigned pos;
    pos = 0;
    while (pos < held && ids[pos] != id) pos++;
    if (pos >= held) return STAT_NOTFOUND;
    // only the first match is looked at
    if (busy[pos]) return STAT_BUSY;
    for (int unsigned k = pos; k + 1 < held; k++) begin
      ids[k]   = ids[k+1];
      sizes[k] = sizes[k+1];
      busy[k]  = busy[k+1];
    end
    held--;
    return STAT_OK;
  endfunction

  function void note_command(logic c, logic [ID_W-1:0] id, logic [SIZE_W-1:0] sz, logic b);
    table_reply_t r;
    r.status = (c == CMD_INSERT) ? insert_entry(id, sz, b) : remove_entry(id);
    r.held   = held[HELD_W-1:0];
    pending_replies.push_back(r);
  endfunction

  function void check_reply(logic [1:0] st, logic [HELD_W-1:0] n);
    table_reply_t r;
    if (pending_replies.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: unexpected result status=%0d entries_held=%0d", st, n);
      return;
    end
    r = pending_replies.pop_front();
    if (st !== r.status || n !== r.held) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: status exp %0d got %0d, entries_held exp %0d got %0d",
                 r.status, st, r.held, n);
    end
  endfunction

  function int unsigned busy_count();
    int unsigned n;
    n = 0;
    for (int unsigned k = 0; k < held; k++) if (busy[k]) n++;
    return n;
  endfunction

  function logic [ID_W-1:0] held_id(int unsigned k);
    return ids[k];
  endfunction
endclass

module tb_sorted_slot_table_top;

  localparam int          DEPTH        = 16;
  localparam int          RANDOM_ITEMS = 880;
  localparam int          PHASE_LEN    = 60;
  localparam int          QUIET_TAIL   = 100;   // last transactions run without idling
  localparam int          LIMIT_CYCLES = 400000;
  localparam int          DRAIN_CYCLES = 40;    // margin past the slowest transaction
  localparam int          HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam logic [15:0] POOL_BASE    = 16'h0040;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic              cmd;
  logic [ID_W-1:0]   table_id;
  logic [SIZE_W-1:0] slot_size;
  logic              busy_flag;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        status;
  logic [HELD_W-1:0] entries_held;

  slot_table_tracker tracker = new();

  bit          idle_on;      // random gaps/stalls allowed in the current phase
  bit          quiet_tail;   // no idling at all from here on
  int unsigned cycles;

  sorted_slot_table_top #(
    .TABLE_DEPTH(DEPTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .table_id     (table_id),
    .slot_size    (slot_size),
    .busy_flag    (busy_flag),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .entries_held (entries_held)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: generous bound on the slowest legal run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offer one command starting at a falling edge, hold it until the
  // block accepts it, then maybe insert a short gap. Valid stays high
  // between back-to-back commands.
  task automatic send_command(input logic c, input logic [ID_W-1:0] id,
                              input logic [SIZE_W-1:0] sz, input logic b);
    cmd       = c;
    table_id  = id;
    slot_size = sz;
    busy_flag = b;
    in_valid  = 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    tracker.note_command(c, id, sz, b);
    @(negedge clk);
    if (idle_on && !quiet_tail && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  // One random command. Delete targets mostly ids that are in the table so
  // the search, busy and gap-closing paths see real traffic; busy inserts are
  // kept few since a busy entry can never leave again.
  task automatic send_random(input int unsigned insert_pct);
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] sz;
    logic              b;
    int unsigned       pick;
    pick = $urandom_range(0, 99);
    sz   = ($urandom_range(0, 9) < 6) ? SIZE_W'($urandom_range(0, 15))
                                      : SIZE_W'($urandom_range(0, 255));
    b    = 1'b0;
    if ($urandom_range(0, 99) < insert_pct) begin
      id = ($urandom_range(0, 9) < 7) ? POOL_BASE + 16'($urandom_range(0, 11))
                                      : ID_W'($urandom_range(0, 65535));
      if (tracker.busy_count() < 3 && $urandom_range(0, 4) == 0) b = 1'b1;
      send_command(CMD_INSERT, id, sz, b);
    end else begin
      if (pick < 60 && tracker.held > 0)
        id = tracker.held_id($urandom_range(0, tracker.held - 1));
      else if (pick < 85)
        id = POOL_BASE + 16'($urandom_range(0, 11));
      else
        id = ID_W'($urandom_range(0, 65535));
      // size and busy are don't-care on delete; wiggle them anyway
      send_command(CMD_DELETE, id, sz, 1'($urandom_range(0, 1)));
    end
  endtask

  // Result side: random short stalls, one long hold-off while the sender
  // keeps pushing so the block backs up and drops in_ready.
  initial begin : result_side
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned results_seen;
    bit          pressure_done;
    stall_left    = 0;
    hold_left     = 0;
    results_seen  = 0;
    pressure_done = 0;
    out_ready     = 1'b0;
    forever begin
      @(negedge clk);
      if (!pressure_done && results_seen >= 200) begin
        hold_left     = HOLD_CYCLES;
        pressure_done = 1;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0 && !quiet_tail) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready  = 1'b1;
        stall_left = 0;
        if (idle_on && !quiet_tail && $urandom_range(0, 5) == 0)
          stall_left = $urandom_range(1, 4);
      end
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && out_ready) begin
        tracker.check_reply(status, entries_held);
        results_seen++;
      end
    end
  end

  initial begin : command_side
    int unsigned insert_pct;
    rst        = 1'b1;
    in_valid   = 1'b0;
    cmd        = CMD_INSERT;
    table_id   = '0;
    slot_size  = '0;
    busy_flag  = 1'b0;
    idle_on    = 1'b1;
    quiet_tail = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // --- directed ---
    send_command(CMD_DELETE, 16'h0000, 8'h00, 1'b0);   // delete on empty table
    send_command(CMD_INSERT, 16'h0000, 8'h00, 1'b0);   // smallest id and size
    send_command(CMD_INSERT, 16'hFFFF, 8'hFF, 1'b1);   // largest, busy
    send_command(CMD_INSERT, 16'hA5A5, 8'hFF, 1'b0);   // tie: lands ahead of 16'hFFFF
    send_command(CMD_DELETE, 16'hFFFF, 8'h00, 1'b0);   // busy, stays
    send_command(CMD_INSERT, 16'hFFFF, 8'd100, 1'b0);  // duplicate id, ahead of busy one
    send_command(CMD_DELETE, 16'hFFFF, 8'h00, 1'b0);   // first match is free -> removed
    send_command(CMD_DELETE, 16'h5A5A, 8'hFF, 1'b1);   // not found
    send_command(CMD_DELETE, 16'hA5A5, 8'h00, 1'b0);   // removed from the middle
    // fill to the brim, with a couple of repeated ids and tied sizes
    for (int k = 0; k < DEPTH - 2; k++)
      send_command(CMD_INSERT, 16'h0100 + 16'(k % 12), 8'($urandom_range(0, 7) * 32), 1'b0);
    send_command(CMD_INSERT, 16'h7777, 8'h10, 1'b0);   // table full
    send_command(CMD_DELETE, 16'h0000, 8'h00, 1'b0);   // delete from a full table

    // --- random: phases swing the table between nearly empty and full ---
    insert_pct = 25;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) begin
        insert_pct = (insert_pct == 25) ? 75 : 25;
        idle_on    = ($urandom_range(0, 2) != 0);
      end
      if (n == RANDOM_ITEMS - QUIET_TAIL) quiet_tail = 1'b1;
      send_random(insert_pct);
    end
    in_valid = 1'b0;

    // drain: watchdog covers a result that never shows
    while (tracker.pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
